// ----- hw/rtl/lzw_pkg.sv -----
// shared constants, types and helpers for the lzw gif encoder
package lzw_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int DICT_ENTRIES  = 4096;
    localparam int BYTE_SZ       = 8;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int ADDR_W        = $clog2(DICT_ENTRIES);
    localparam int NF_W          = ADDR_W + 1;
    localparam int KEY_W         = CODE_W + BYTE_SZ;
    localparam int ENT_W         = KEY_W + ADDR_W;
    localparam int CW_W          = 4;
    localparam int MCS_W         = 4;
    localparam int CODE_LIMIT    = (DICT_ENTRIES < (1 << MAX_CODE_BITS)) ?
                                   DICT_ENTRIES : (1 << MAX_CODE_BITS);
    localparam int BUF_W         = CODE_W + BYTE_SZ;
    localparam int CNT_W         = $clog2(BUF_W + 1);
    localparam logic [MCS_W-1:0] MCS_RESET = MCS_W'(8);

    typedef struct packed {
        logic [BYTE_SZ-1:0] sym;
        logic               last;
    } sym_item_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic [CW_W-1:0]   width;
        logic              flush;
    } code_req_t;

    typedef enum logic [3:0] {
        C_CLEAR,
        C_IDLE,
        C_HEAD_RD,
        C_HEAD_CHK,
        C_ENT_CHK,
        C_MISS,
        C_EMIT_CLR,
        C_EMIT_PFX,
        C_EMIT_FIN,
        C_EMIT_END
    } core_state_t;

    function automatic logic [ADDR_W-1:0] key_hash(input logic [KEY_W-1:0] key);
        logic [ADDR_W-1:0] p;
        logic [ADDR_W-1:0] s;
        p = key[KEY_W-1 -: ADDR_W];
        s = ADDR_W'(key[BYTE_SZ-1:0]) << 4;
        return p ^ s;
    endfunction

endpackage

// ----- hw/rtl/lzw_gif_encoder_unit.sv -----
// top level of the gif-style variable-width lzw encoder
// Bytes enter on s_axis (tlast on the final byte of a stream) and packed
// code bytes leave on m_axis, lsb first, tlast on the last byte of the stream;
// empty streams are not supported. After reset the head table is swept clear,
// and no input item is taken during the sweep. The first byte of a stream
// sends a clear code. Any later byte takes a hash bucket probe and one
// dictionary read, both through synchronous memories, plus one more dictionary
// read per extra entry on the bucket chain. A miss adds an insert state, and
// each code handed to the packer adds an emit state that waits longer while
// the packer is still draining. The packer drains one byte per cycle while
// m_axis_tready is high. Writing cfg_wr_data (min code size, clamped to 2..8)
// with cfg_wr_en restarts the stream and is meant for an idle block.
module lzw_gif_encoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lzw_pkg::MCS_W-1:0]     cfg_wr_data,   // min_code_size
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lzw_pkg::BYTE_SZ-1:0]   s_axis_tdata,  // in_byte
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lzw_pkg::BYTE_SZ-1:0]   m_axis_tdata,  // out_byte
    output logic                          m_axis_tlast
);

    logic [lzw_pkg::MCS_W-1:0] mcs_reg, mcs_next;
    logic [lzw_pkg::MCS_W-1:0] min_eff;
    logic                      core_ready, q_valid, q_pop, req_ready;
    lzw_pkg::sym_item_t        q_item;
    lzw_pkg::code_req_t        req;

    assign mcs_next = cfg_wr_en ? cfg_wr_data : mcs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcs_reg <= lzw_pkg::MCS_RESET;
        end
        else
        begin
            mcs_reg <= mcs_next;
        end
    end

    always_comb
    begin
        priority if (mcs_next < lzw_pkg::MCS_W'(2))
        begin
            min_eff = lzw_pkg::MCS_W'(2);
        end
        else if (mcs_next > lzw_pkg::MCS_W'(8))
        begin
            min_eff = lzw_pkg::MCS_W'(8);
        end
        else
        begin
            min_eff = mcs_next;
        end
    end

    lzw_fe u_fe (
        .clk           (clk),
        .rst_n         (rst_n),
        .enable        (core_ready),
        .min_eff       (min_eff),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    lzw_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (cfg_wr_en),
        .min_eff   (min_eff),
        .ready_in  (core_ready),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .req       (req),
        .req_ready (req_ready)
    );

    lzw_pack u_pack (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (cfg_wr_en),
        .req           (req),
        .req_ready     (req_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- hw/rtl/lzw_ram.sv -----
// generic single write, single read ram with registered read data
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lzw_fe.sv -----
// front end: accepts input items, masks the symbol, two-entry queue to the core
module lzw_fe (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           enable,
    input  logic [lzw_pkg::MCS_W-1:0]      min_eff,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [lzw_pkg::BYTE_SZ-1:0]    s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           q_valid,
    output lzw_pkg::sym_item_t             q_item,
    input  logic                           q_pop
);

    lzw_pkg::sym_item_t slot_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic [lzw_pkg::BYTE_SZ-1:0] mask;
    lzw_pkg::sym_item_t in_item;

    assign mask          = ~({lzw_pkg::BYTE_SZ{1'b1}} << min_eff);
    assign in_item.sym   = s_axis_tdata & mask;
    assign in_item.last  = s_axis_tlast;
    assign s_axis_tready = enable && (cnt_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (cnt_reg != 2'd0);
    assign q_item        = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/lzw_core.sv -----
// back end: hashed dictionary lookup, insert and code sequencing
module lzw_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      restart,
    input  logic [lzw_pkg::MCS_W-1:0] min_eff,
    output logic                      ready_in,
    input  logic                      q_valid,
    input  lzw_pkg::sym_item_t        q_item,
    output logic                      q_pop,
    output lzw_pkg::code_req_t        req,
    input  logic                      req_ready
);

    localparam int AW = lzw_pkg::ADDR_W;
    localparam int CW = lzw_pkg::CODE_W;
    localparam int KW = lzw_pkg::KEY_W;

    lzw_pkg::core_state_t state_reg, state_next;

    logic [AW-1:0]              clr_addr_reg, clr_addr_next;
    logic [lzw_pkg::BYTE_SZ-1:0] sym_reg, sym_next;
    logic                       last_reg, last_next;
    logic [CW-1:0]              prefix_reg, prefix_next;
    logic [lzw_pkg::NF_W-1:0]   nf_reg, nf_next;
    logic [lzw_pkg::CW_W-1:0]   width_reg, width_next;
    logic                       started_reg, started_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [AW-1:0]              cur_reg, cur_next;

    logic                  head_we;
    logic [AW-1:0]         head_waddr, head_wdata, head_raddr, head_rdata;
    logic                  dict_we;
    logic [AW-1:0]         dict_waddr, dict_raddr;
    logic [lzw_pkg::ENT_W-1:0] dict_wdata, dict_rdata;

    logic [CW-1:0]  alpha, first;
    logic [KW-1:0]  want_key, ent_key;
    logic [AW-1:0]  ent_next, hsh;
    logic           head_ok, ent_same_bucket, ent_hit, nxt_ok;
    logic [lzw_pkg::CW_W-1:0] min_p1;

    assign alpha    = CW'(1) << min_eff;
    assign first    = alpha + CW'(2);
    assign min_p1   = min_eff + lzw_pkg::CW_W'(1);
    assign want_key = {prefix_reg, sym_reg};
    assign hsh      = lzw_pkg::key_hash(want_key);
    assign ent_key  = dict_rdata[KW-1:0];
    assign ent_next = dict_rdata[lzw_pkg::ENT_W-1:KW];
    assign head_ok  = (lzw_pkg::NF_W'(head_rdata) >= lzw_pkg::NF_W'(first)) &&
                      (lzw_pkg::NF_W'(head_rdata) < nf_reg);
    assign ent_same_bucket = (lzw_pkg::key_hash(ent_key) == hsh);
    assign ent_hit  = ent_same_bucket && (ent_key == want_key);
    assign nxt_ok   = (ent_next >= AW'(first)) && (ent_next < cur_reg);
    assign ready_in = (state_reg != lzw_pkg::C_CLEAR);

    lzw_ram #(.WIDTH(AW), .DEPTH(lzw_pkg::DICT_ENTRIES)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    lzw_ram #(.WIDTH(lzw_pkg::ENT_W), .DEPTH(lzw_pkg::DICT_ENTRIES)) u_dict_ram (
        .clk   (clk),
        .we    (dict_we),
        .waddr (dict_waddr),
        .wdata (dict_wdata),
        .raddr (dict_raddr),
        .rdata (dict_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lzw_pkg::C_CLEAR:
            begin
                if (clr_addr_reg == AW'(lzw_pkg::DICT_ENTRIES - 1))
                begin
                    state_next = lzw_pkg::C_IDLE;
                end
            end
            lzw_pkg::C_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = started_reg ? lzw_pkg::C_HEAD_RD : lzw_pkg::C_EMIT_CLR;
                end
            end
            lzw_pkg::C_HEAD_RD:
            begin
                state_next = lzw_pkg::C_HEAD_CHK;
            end
            lzw_pkg::C_HEAD_CHK:
            begin
                state_next = head_ok ? lzw_pkg::C_ENT_CHK : lzw_pkg::C_MISS;
            end
            lzw_pkg::C_ENT_CHK:
            begin
                priority if (ent_hit)
                begin
                    state_next = last_reg ? lzw_pkg::C_EMIT_FIN : lzw_pkg::C_IDLE;
                end
                else if (!ent_same_bucket || !nxt_ok)
                begin
                    state_next = lzw_pkg::C_MISS;
                end
                else
                begin
                    state_next = lzw_pkg::C_ENT_CHK;
                end
            end
            lzw_pkg::C_MISS:
            begin
                state_next = lzw_pkg::C_EMIT_PFX;
            end
            lzw_pkg::C_EMIT_CLR, lzw_pkg::C_EMIT_PFX:
            begin
                if (req_ready)
                begin
                    state_next = last_reg ? lzw_pkg::C_EMIT_FIN : lzw_pkg::C_IDLE;
                end
            end
            lzw_pkg::C_EMIT_FIN:
            begin
                if (req_ready)
                begin
                    state_next = lzw_pkg::C_EMIT_END;
                end
            end
            lzw_pkg::C_EMIT_END:
            begin
                if (req_ready)
                begin
                    state_next = lzw_pkg::C_IDLE;
                end
            end
            default:
            begin
                state_next = lzw_pkg::C_IDLE;
            end
        endcase
        if (restart && state_reg != lzw_pkg::C_CLEAR)
        begin
            state_next = lzw_pkg::C_IDLE;
        end
    end

    // outputs and datapath
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        sym_next      = sym_reg;
        last_next     = last_reg;
        prefix_next   = prefix_reg;
        nf_next       = nf_reg;
        width_next    = width_reg;
        started_next  = started_reg;
        head_next     = head_reg;
        cur_next      = cur_reg;
        head_we       = 1'b0;
        head_waddr    = hsh;
        head_wdata    = AW'(nf_reg);
        head_raddr    = hsh;
        dict_we       = 1'b0;
        dict_waddr    = AW'(nf_reg);
        dict_wdata    = {head_reg, want_key};
        dict_raddr    = cur_reg;
        q_pop         = 1'b0;
        req.valid     = 1'b0;
        req.code      = prefix_reg;
        req.width     = width_reg;
        req.flush     = 1'b0;

        unique case (state_reg)
            lzw_pkg::C_CLEAR:
            begin
                head_we       = 1'b1;
                head_waddr    = clr_addr_reg;
                head_wdata    = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            lzw_pkg::C_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    sym_next  = q_item.sym;
                    last_next = q_item.last;
                end
            end
            lzw_pkg::C_HEAD_RD:
            begin
                head_raddr = hsh;
            end
            lzw_pkg::C_HEAD_CHK:
            begin
                head_next  = head_rdata;
                cur_next   = head_rdata;
                dict_raddr = head_rdata;
            end
            lzw_pkg::C_ENT_CHK:
            begin
                if (ent_hit)
                begin
                    prefix_next = CW'(cur_reg);
                end
                else
                begin
                    cur_next   = ent_next;
                    dict_raddr = ent_next;
                end
            end
            lzw_pkg::C_MISS:
            begin
                if (nf_reg < lzw_pkg::NF_W'(lzw_pkg::CODE_LIMIT))
                begin
                    dict_we  = 1'b1;
                    head_we  = 1'b1;
                    nf_next  = nf_reg + lzw_pkg::NF_W'(1);
                    if (width_reg < lzw_pkg::CW_W'(lzw_pkg::MAX_CODE_BITS) &&
                        nf_reg == (lzw_pkg::NF_W'(1) << width_reg))
                    begin
                        width_next = width_reg + lzw_pkg::CW_W'(1);
                    end
                end
            end
            lzw_pkg::C_EMIT_CLR:
            begin
                req.valid = 1'b1;
                req.code  = alpha;
                if (req_ready)
                begin
                    started_next = 1'b1;
                    prefix_next  = CW'(sym_reg);
                end
            end
            lzw_pkg::C_EMIT_PFX:
            begin
                req.valid = 1'b1;
                if (req_ready)
                begin
                    prefix_next = CW'(sym_reg);
                end
            end
            lzw_pkg::C_EMIT_FIN:
            begin
                req.valid = 1'b1;
            end
            lzw_pkg::C_EMIT_END:
            begin
                req.valid = 1'b1;
                req.code  = alpha + CW'(1);
                req.flush = 1'b1;
                if (req_ready)
                begin
                    prefix_next  = '0;
                    nf_next      = lzw_pkg::NF_W'(first);
                    width_next   = min_p1;
                    started_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (restart)
        begin
            prefix_next  = '0;
            nf_next      = lzw_pkg::NF_W'(first);
            width_next   = min_p1;
            started_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg  <= sym_next;
        last_reg <= last_next;
        head_reg <= head_next;
        cur_reg  <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lzw_pkg::C_CLEAR;
            clr_addr_reg <= '0;
            prefix_reg   <= '0;
            nf_reg       <= lzw_pkg::NF_W'((1 << 8) + 2);
            width_reg    <= lzw_pkg::CW_W'(9);
            started_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            prefix_reg   <= prefix_next;
            nf_reg       <= nf_next;
            width_reg    <= width_next;
            started_reg  <= started_next;
        end
    end

endmodule

// ----- hw/rtl/lzw_pack.sv -----
// bit packer: codes in, lsb-first bytes out through an output register
module lzw_pack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  lzw_pkg::code_req_t            req,
    output logic                          req_ready,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lzw_pkg::BYTE_SZ-1:0]   m_axis_tdata,
    output logic                          m_axis_tlast
);

    localparam int BW = lzw_pkg::BUF_W;
    localparam int NW = lzw_pkg::CNT_W;

    logic [BW-1:0]               buf_reg, buf_next;
    logic [NW-1:0]               cnt_reg, cnt_next;
    logic                        pend_reg, pend_next;
    logic                        ov_reg, ov_next;
    logic [lzw_pkg::BYTE_SZ-1:0] ob_reg, ob_next;
    logic                        ol_reg, ol_next;
    logic                        slot_free, emit, take, is_last;
    logic [lzw_pkg::CODE_W-1:0]  cmask;

    assign cmask     = ~({lzw_pkg::CODE_W{1'b1}} << req.width);
    assign slot_free = !ov_reg || m_axis_tready;
    assign req_ready = (cnt_reg < NW'(lzw_pkg::BYTE_SZ)) && !pend_reg;
    assign take      = req.valid && req_ready;
    assign emit      = slot_free &&
                       ((cnt_reg >= NW'(lzw_pkg::BYTE_SZ)) || (pend_reg && cnt_reg != '0));
    assign is_last   = pend_reg && (cnt_reg <= NW'(lzw_pkg::BYTE_SZ));

    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        pend_next = pend_reg;
        ov_next   = ov_reg && !m_axis_tready;
        ob_next   = ob_reg;
        ol_next   = ol_reg;
        if (take)
        begin
            buf_next  = buf_reg | (BW'(req.code & cmask) << cnt_reg[2:0]);
            cnt_next  = cnt_reg + NW'(req.width);
            pend_next = req.flush;
        end
        else if (emit)
        begin
            ov_next  = 1'b1;
            ob_next  = buf_reg[lzw_pkg::BYTE_SZ-1:0];
            ol_next  = is_last;
            buf_next = buf_reg >> lzw_pkg::BYTE_SZ;
            if (is_last)
            begin
                cnt_next  = '0;
                pend_next = 1'b0;
                buf_next  = '0;
            end
            else
            begin
                cnt_next = cnt_reg - NW'(lzw_pkg::BYTE_SZ);
            end
        end
        if (restart)
        begin
            buf_next  = '0;
            cnt_next  = '0;
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
        ol_reg <= ol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            buf_reg  <= buf_next;
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            ov_reg   <= ov_next;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = ob_reg;
    assign m_axis_tlast  = ol_reg;

endmodule

// ----- tb/lzw_gif_encoder_unit_checker.sv -----
// checker for the lzw gif encoder: predicts output bytes and compares them
`timescale 1ns / 1ps

module lzw_gif_encoder_unit_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lzw_pkg::MCS_W-1:0]   cfg_wr_data,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [lzw_pkg::BYTE_SZ-1:0] s_axis_tdata,   // in_byte
    input  logic                        s_axis_tlast,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [lzw_pkg::BYTE_SZ-1:0] m_axis_tdata,   // out_byte
    input  logic                        m_axis_tlast,
    output int                          errors,
    output int                          pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } packed_byte_t;

    packed_byte_t   byte_q[$];
    logic [19:0]    dict_mem [0:lzw_pkg::DICT_ENTRIES-1];
    logic [3:0]     code_size_reg;
    int unsigned    prefix_code;
    int unsigned    free_code;
    int unsigned    width_now;
    int unsigned    acc_bits;
    int unsigned    acc_count;
    bit             in_stream;
    int             step_bytes;

    assign pending = byte_q.size();

    function automatic int unsigned clamp_size(input logic [3:0] v);
        if (v < 2)
            return 2;
        if (v > 8)
            return 8;
        return v;
    endfunction

    task automatic restart_stream();
        prefix_code = 0;
        free_code   = (1 << clamp_size(code_size_reg)) + 2;
        width_now   = clamp_size(code_size_reg) + 1;
        acc_bits    = 0;
        acc_count   = 0;
        in_stream   = 0;
    endtask

    task automatic push_byte(input int unsigned b);
        packed_byte_t e;
        if (step_bytes >= 6)
            return;
        e.data = b[7:0];
        e.last = 1'b0;
        byte_q.push_back(e);
        step_bytes++;
    endtask

    task automatic pack_code(input int unsigned code);
        acc_bits  |= (code & ((1 << width_now) - 1) & 16'hffff) << acc_count;
        acc_count += width_now;
        while (acc_count >= 8)
        begin
            push_byte(acc_bits & 8'hff);
            acc_bits  >>= 8;
            acc_count -= 8;
        end
    endtask

    task automatic encode_symbol(input logic [7:0] raw, input logic is_last);
        int unsigned alpha;
        int unsigned sym;
        int unsigned key;
        int unsigned c;
        bit          hit;
        alpha      = 1 << clamp_size(code_size_reg);
        sym        = raw & (alpha - 1);
        step_bytes = 0;
        if (!in_stream)
        begin
            pack_code(alpha);
            in_stream   = 1;
            prefix_code = sym;
        end
        else
        begin
            hit = 0;
            key = (prefix_code << 8) | sym;
            for (c = alpha + 2; c < free_code && c < lzw_pkg::DICT_ENTRIES; c++)
            begin
                if (!hit && dict_mem[c] == key[19:0])
                begin
                    hit         = 1;
                    prefix_code = c;
                end
            end
            if (!hit)
            begin
                if (free_code < lzw_pkg::CODE_LIMIT)
                begin
                    dict_mem[free_code] = key[19:0];
                    if (width_now < lzw_pkg::MAX_CODE_BITS && free_code == (1 << width_now))
                        width_now++;
                    free_code++;
                end
                pack_code(prefix_code);
                prefix_code = sym;
            end
        end
        if (is_last)
        begin
            pack_code(prefix_code);
            pack_code(alpha + 1);
            if (acc_count != 0)
                push_byte(acc_bits & 8'hff);
            if (step_bytes > 0)
                byte_q[$].last = 1'b1;
            restart_stream();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors        <= 0;
            code_size_reg = lzw_pkg::MCS_RESET;
            restart_stream();
            byte_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                code_size_reg = cfg_wr_data;
                restart_stream();
            end
            if (s_axis_tvalid && s_axis_tready)
                encode_symbol(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (byte_q.size() == 0)
                begin
                    $error("unexpected item: out_byte %0h out_last %0b",
                           m_axis_tdata, m_axis_tlast);
                    errors <= errors + 1;
                end
                else
                begin
                    if (m_axis_tdata !== byte_q[0].data || m_axis_tlast !== byte_q[0].last)
                    begin
                        if (m_axis_tdata !== byte_q[0].data)
                            $error("out_byte expected %0h actual %0h",
                                   byte_q[0].data, m_axis_tdata);
                        if (m_axis_tlast !== byte_q[0].last)
                            $error("out_last expected %0b actual %0b",
                                   byte_q[0].last, m_axis_tlast);
                        errors <= errors + 1;
                    end
                    void'(byte_q.pop_front());
                end
            end
        end
    end

endmodule

// ----- tb/lzw_gif_encoder_unit_tb.sv -----
// testbench top for the lzw gif encoder: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module lzw_gif_encoder_unit_tb;

    localparam int WATCHDOG_LIMIT = 40000;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [lzw_pkg::MCS_W-1:0]   cfg_wr_data;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [lzw_pkg::BYTE_SZ-1:0] s_axis_tdata;
    logic                        s_axis_tlast;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [lzw_pkg::BYTE_SZ-1:0] m_axis_tdata;
    logic                        m_axis_tlast;
    int                          errors;
    int                          pending;
    int                          send_idle_pct;
    int                          recv_stall_pct;
    int                          quiet_cycles;

    lzw_gif_encoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    lzw_gif_encoder_unit_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_symbol(input logic [7:0] b, input logic l);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_code_size(input logic [3:0] v);
        drain_outputs();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // mostly repetitive content so the dictionary gets hits
    task automatic random_stream(input int len);
        int          i;
        int unsigned pool;
        logic [7:0]  b;
        pool = $urandom_range(1, 8);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                b = 8'($urandom);
            else
                b = 8'($urandom_range(0, pool - 1)) | (8'($urandom) & 8'hf0);
            send_symbol(b, i == len - 1);
        end
    endtask

    initial
    begin
        int          p;
        int          k;
        int          i;
        logic [3:0]  sizes[10] = '{4'd2, 4'd8, 4'd5, 4'd0, 4'd15, 4'd3, 4'd9, 4'd1, 4'd4, 4'd7};
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: one-byte streams, extremes, repeats
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hff, 1'b1);
        for (i = 0; i < 8; i++)
            send_symbol((i % 2) ? 8'h61 : 8'h62, i == 7);
        send_symbol(8'hff, 1'b0);
        send_symbol(8'h00, 1'b1);
        set_code_size(4'd2);
        for (i = 0; i < 6; i++)
            send_symbol(8'hff - i[7:0], i == 5);
        set_code_size(4'd15);
        send_symbol(8'hab, 1'b1);
        set_code_size(4'd0);
        send_symbol(8'h05, 1'b0);
        send_symbol(8'hfe, 1'b1);

        // random phases
        for (p = 0; p < 4; p++)
        begin
            send_idle_pct  = (p == 1 || p == 3) ? ((p == 3) ? 34 : 62) : 0;
            recv_stall_pct = (p == 2 || p == 3) ? ((p == 3) ? 34 : 62) : 0;
            for (k = 0; k < 3; k++)
            begin
                set_code_size(sizes[(p * 3 + k) % 10]);
                for (i = 0; i < 4; i++)
                begin
                    int len;
                    len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 16);
                    random_stream(len);
                end
            end
        end

        // random bytes over the full alphabet, then a random stream at min code size 2
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_code_size(4'd8);
        for (i = 0; i < 40; i++)
            send_symbol(8'($urandom), i == 39);
        set_code_size(4'd2);
        random_stream(40);

        drain_outputs();
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
